[rtl/core/ptmc_pkg.sv]
package ptmc_pkg;

	// Default width of the millisecond timers
	localparam int TIMER_WIDTH_DEF = 16;

	// Field widths
	localparam int SPEED_CFG_W = 10;
	localparam int SPEED_W     = 11;
	localparam int POS_W       = 16;
	localparam int MS_W        = 16;
	localparam int CMD_W       = 3;
	localparam int IDX_W       = 3;
	localparam int DATA_W      = 16;

	// Vision commands; codes 4..7 behave as hold
	localparam logic [CMD_W-1:0] CMD_POS  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_HOLD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_NEG  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOST = 3'd3;

	// Item kinds
	localparam logic ACT_COMMAND = 1'b0;
	localparam logic ACT_TICK    = 1'b1;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_TRACK_SPEED = 3'd0;
	localparam logic [IDX_W-1:0] REG_SWEEP_SPEED = 3'd1;
	localparam logic [IDX_W-1:0] REG_LOW_LIMIT   = 3'd2;
	localparam logic [IDX_W-1:0] REG_HIGH_LIMIT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_TIMEOUT     = 3'd4;
	localparam logic [IDX_W-1:0] REG_DELAY       = 3'd5;

	// Register reset values
	localparam logic [SPEED_CFG_W-1:0] TRACK_SPEED_RST = 10'd50;
	localparam logic [SPEED_CFG_W-1:0] SWEEP_SPEED_RST = 10'd30;
	localparam logic signed [POS_W-1:0] LOW_LIMIT_RST  = -16'sd512;
	localparam logic signed [POS_W-1:0] HIGH_LIMIT_RST = 16'sd512;
	localparam logic [MS_W-1:0] TIMEOUT_RST = 16'd500;
	localparam logic [MS_W-1:0] DELAY_RST   = 16'd3000;

	typedef struct packed {
		logic [SPEED_CFG_W-1:0]   track_speed;
		logic [SPEED_CFG_W-1:0]   sweep_speed;
		logic signed [POS_W-1:0]  low_limit;
		logic signed [POS_W-1:0]  high_limit;
		logic [MS_W-1:0]          command_timeout_ms;
		logic [MS_W-1:0]          search_delay_ms;
	} cfg_t;

endpackage

[rtl/core/ptmc_cfg_regs.sv]
module ptmc_cfg_regs
	import ptmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0] wr_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	// Write one register per transaction; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track_speed        <= TRACK_SPEED_RST;
			cfg_q.sweep_speed        <= SWEEP_SPEED_RST;
			cfg_q.low_limit          <= LOW_LIMIT_RST;
			cfg_q.high_limit         <= HIGH_LIMIT_RST;
			cfg_q.command_timeout_ms <= TIMEOUT_RST;
			cfg_q.search_delay_ms    <= DELAY_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_TRACK_SPEED: cfg_q.track_speed        <= wr_data[SPEED_CFG_W-1:0];
				REG_SWEEP_SPEED: cfg_q.sweep_speed        <= wr_data[SPEED_CFG_W-1:0];
				REG_LOW_LIMIT:   cfg_q.low_limit          <= signed'(wr_data[POS_W-1:0]);
				REG_HIGH_LIMIT:  cfg_q.high_limit         <= signed'(wr_data[POS_W-1:0]);
				REG_TIMEOUT:     cfg_q.command_timeout_ms <= wr_data[MS_W-1:0];
				REG_DELAY:       cfg_q.search_delay_ms    <= wr_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/ptmc_core.sv]
module ptmc_core
	import ptmc_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     fire,
	input  logic                     action,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [POS_W-1:0]  position,
	output logic signed [SPEED_W-1:0] speed,
	output logic [CMD_W-1:0]         mode,
	output logic                     sweeping
);

	localparam int CMP_W = (TIMER_WIDTH > MS_W) ? TIMER_WIDTH : MS_W;

	logic [CMD_W-1:0]       active_q;
	logic                   ever_q;
	logic [TIMER_WIDTH-1:0] since_q;
	logic                   armed_q;
	logic [TIMER_WIDTH-1:0] elapsed_q;
	logic                   sweep_neg_q;

	logic [CMD_W-1:0]       active_n;
	logic                   ever_n;
	logic [TIMER_WIDTH-1:0] since_n;
	logic                   armed_n;
	logic [TIMER_WIDTH-1:0] elapsed_n;
	logic                   sweep_neg_n;
	logic [TIMER_WIDTH-1:0] since_inc;
	logic [TIMER_WIDTH-1:0] elapsed_inc;
	logic                   timed_out;
	logic                   delay_passed;
	logic signed [SPEED_W-1:0] track_mag;
	logic signed [SPEED_W-1:0] sweep_mag;

	// Saturating timer increments
	assign since_inc   = (&since_q) ? since_q : since_q + 1'b1;
	assign elapsed_inc = armed_q ? ((&elapsed_q) ? elapsed_q : elapsed_q + 1'b1) : elapsed_q;

	assign timed_out    = ever_q && (CMP_W'(since_inc) > CMP_W'(cfg.command_timeout_ms));
	assign delay_passed = CMP_W'(elapsed_inc) > CMP_W'(cfg.search_delay_ms);

	assign track_mag = signed'({1'b0, cfg.track_speed});
	assign sweep_mag = signed'({1'b0, cfg.sweep_speed});

	// Next state and tick result
	always_comb begin
		active_n    = active_q;
		ever_n      = ever_q;
		since_n     = since_q;
		armed_n     = armed_q;
		elapsed_n   = elapsed_q;
		sweep_neg_n = sweep_neg_q;
		speed       = '0;
		sweeping    = 1'b0;
		if (action == ACT_COMMAND) begin
			ever_n   = 1'b1;
			since_n  = '0;
			active_n = command;
			if (command != CMD_LOST) begin
				armed_n   = 1'b0;
				elapsed_n = '0;
			end
		end else begin
			since_n   = since_inc;
			elapsed_n = elapsed_inc;
			if (timed_out)
				active_n = CMD_HOLD;
			case (active_n)
				CMD_POS: begin
					if (position < cfg.high_limit)
						speed = track_mag;
				end
				CMD_NEG: begin
					if (position > cfg.low_limit)
						speed = -track_mag;
				end
				CMD_LOST: begin
					if (!armed_q) begin
						armed_n   = 1'b1;
						elapsed_n = '0;
					end else if (delay_passed) begin
						if (position >= cfg.high_limit)
							sweep_neg_n = 1'b1;
						if (position <= cfg.low_limit)
							sweep_neg_n = 1'b0;
						speed    = sweep_neg_n ? -sweep_mag : sweep_mag;
						sweeping = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign mode = active_n;

	// Commit state for each item processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= CMD_HOLD;
			ever_q      <= 1'b0;
			since_q     <= '0;
			armed_q     <= 1'b0;
			elapsed_q   <= '0;
			sweep_neg_q <= 1'b0;
		end else if (fire) begin
			active_q    <= active_n;
			ever_q      <= ever_n;
			since_q     <= since_n;
			armed_q     <= armed_n;
			elapsed_q   <= elapsed_n;
			sweep_neg_q <= sweep_neg_n;
		end
	end

endmodule

[rtl/core/pan_tracking_mode_controller.sv]
// Pan tracking mode controller.
// Input channel (in_valid/in_ready): one item per transaction, either a vision
// command (action 0) or a one millisecond tick carrying the motor position
// (action 1). Output channel (out_valid/out_ready): one result per tick with
// the signed speed, the mode in effect and the sweep flag; commands give none.
// Configuration channel (cfg_valid/cfg_ready): always ready, one register per
// transaction; the user must write it only while the block is idle, which
// the block does not enforce. An accepted item enters the input register,
// and a tick's result then goes into the output register and raises out_valid.
// Throughput is one item per cycle while the receiver keeps up, set by the
// single input register feeding the state update and the output register.
// When the receiver stalls, the result holds in the output register; a command
// item still moves through, a tick waits in the input register, and in_ready
// drops only once both registers are full.
// Reset clears the mode to hold, all timers, the lost flags and the sweep
// direction, loads the register defaults and empties both stages.
module pan_tracking_mode_controller
	import ptmc_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [CMD_W-1:0]          command,
	input  logic signed [POS_W-1:0]   position,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [SPEED_W-1:0] speed,
	output logic [CMD_W-1:0]          mode,
	output logic                      sweeping,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [DATA_W-1:0]         cfg_data
);

	cfg_t cfg;

	logic                      valid_s1;
	logic                      action_s1;
	logic [CMD_W-1:0]          command_s1;
	logic signed [POS_W-1:0]   position_s1;
	logic                      advance_s1;
	logic                      out_free;

	logic signed [SPEED_W-1:0] core_speed;
	logic [CMD_W-1:0]          core_mode;
	logic                      core_sweeping;

	logic                      out_valid_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic [CMD_W-1:0]          mode_q;
	logic                      sweeping_q;

	assign cfg_ready = 1'b1;

	ptmc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Stage 1 moves on unless it holds a tick and the output is full and not being read
	assign out_free   = !out_valid_q || out_ready;
	assign advance_s1 = valid_s1 && ((action_s1 == ACT_COMMAND) || out_free);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// Capture the payload on each input transaction
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1   <= action;
			command_s1  <= command;
			position_s1 <= position;
		end
	end

	ptmc_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.fire     (advance_s1),
		.action   (action_s1),
		.command  (command_s1),
		.position (position_s1),
		.speed    (core_speed),
		.mode     (core_mode),
		.sweeping (core_sweeping)
	);

	// Output register: load on a processed tick, drop on an output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance_s1 && (action_s1 == ACT_TICK))
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && (action_s1 == ACT_TICK)) begin
			speed_q    <= core_speed;
			mode_q     <= core_mode;
			sweeping_q <= core_sweeping;
		end
	end

	assign out_valid = out_valid_q;
	assign speed     = speed_q;
	assign mode      = mode_q;
	assign sweeping  = sweeping_q;

endmodule

[bench/pan_tracking_mode_controller_test.sv]
module pan_tracking_mode_controller_test;
	import ptmc_pkg::*;

	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 200;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 158;
	localparam int QUIET_PHASE    = 4;
	localparam int STALL_PHASE    = 3;
	localparam int NUM_DIRECTED   = 30;
	localparam logic [TIMER_WIDTH_DEF-1:0] TIMER_MAX = '1;

	// One speed result as the block reports it
	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [CMD_W-1:0]   mode;
		logic               sweeping;
	} drive_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	// Directed row: sel is the command on items and the register index on writes,
	// data is the position on items and the register value on writes
	typedef struct packed {
		row_kind_e          kind;
		logic               act;
		logic [CMD_W-1:0]   sel;
		logic [DATA_W-1:0]  data;
		logic               typed;
		drive_t             want;
	} step_t;

	localparam step_t DIRECTED [NUM_DIRECTED] = '{
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd0,        1'b1, '{11'd0,        CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_COMMAND, CMD_POS,  16'd0,        1'b0, '{11'd0,        CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd0,        1'b1, '{11'd50,       CMD_POS,  1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'h7FFF,     1'b1, '{11'd0,        CMD_POS,  1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd512,      1'b1, '{11'd0,        CMD_POS,  1'b0}},
		'{ROW_ITEM, ACT_COMMAND, CMD_NEG,  16'd0,        1'b0, '{11'd0,        CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'h8000,     1'b1, '{11'd0,        CMD_NEG,  1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, -16'sd512,    1'b1, '{11'd0,        CMD_NEG,  1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, -16'sd511,    1'b1, '{-11'sd50,     CMD_NEG,  1'b0}},
		'{ROW_ITEM, ACT_COMMAND, 3'd7,     16'd0,        1'b0, '{11'd0,        CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'hFFFF,     1'b1, '{11'd0,        3'd7,     1'b0}},
		'{ROW_CFG,  ACT_TICK,    REG_TRACK_SPEED, 16'd1023, 1'b0, '{11'd0,     CMD_HOLD, 1'b0}},
		'{ROW_CFG,  ACT_TICK,    REG_SWEEP_SPEED, 16'd1023, 1'b0, '{11'd0,     CMD_HOLD, 1'b0}},
		'{ROW_CFG,  ACT_TICK,    REG_TIMEOUT,     16'd5,    1'b0, '{11'd0,     CMD_HOLD, 1'b0}},
		'{ROW_CFG,  ACT_TICK,    REG_DELAY,       16'd1,    1'b0, '{11'd0,     CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_COMMAND, CMD_LOST, 16'd0,        1'b0, '{11'd0,        CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd0,        1'b1, '{11'd0,        CMD_LOST, 1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd0,        1'b1, '{11'd0,        CMD_LOST, 1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd600,      1'b1, '{-11'sd1023,   CMD_LOST, 1'b1}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, -16'sd600,    1'b1, '{11'd1023,     CMD_LOST, 1'b1}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd0,        1'b1, '{11'd1023,     CMD_LOST, 1'b1}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd0,        1'b1, '{11'd0,        CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_COMMAND, CMD_LOST, 16'd0,        1'b0, '{11'd0,        CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd0,        1'b0, '{11'd0,        CMD_HOLD, 1'b0}},
		'{ROW_CFG,  ACT_TICK,    REG_LOW_LIMIT,  16'd100,   1'b0, '{11'd0,     CMD_HOLD, 1'b0}},
		'{ROW_CFG,  ACT_TICK,    REG_HIGH_LIMIT, -16'sd100, 1'b0, '{11'd0,     CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd0,        1'b0, '{11'd0,        CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd200,      1'b0, '{11'd0,        CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_COMMAND, CMD_POS,  16'd0,        1'b0, '{11'd0,        CMD_HOLD, 1'b0}},
		'{ROW_ITEM, ACT_TICK,    CMD_HOLD, 16'd0,        1'b0, '{11'd0,        CMD_HOLD, 1'b0}}
	};

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      action;
	logic [CMD_W-1:0]          command;
	logic signed [POS_W-1:0]   position;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [SPEED_W-1:0] speed;
	logic [CMD_W-1:0]          mode;
	logic                      sweeping;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [IDX_W-1:0]          cfg_index;
	logic [DATA_W-1:0]         cfg_data;

	// Shadow registers
	logic [SPEED_CFG_W-1:0]  r_track;
	logic [SPEED_CFG_W-1:0]  r_sweep;
	logic signed [POS_W-1:0] r_low;
	logic signed [POS_W-1:0] r_high;
	logic [MS_W-1:0]         r_timeout;
	logic [MS_W-1:0]         r_delay;

	// Predicted controller state
	logic [CMD_W-1:0]           mode_now;
	logic                       ever_cmd;
	logic [TIMER_WIDTH_DEF-1:0] ms_since_cmd;
	logic                       lost_armed;
	logic [TIMER_WIDTH_DEF-1:0] lost_ms;
	logic                       sweep_down;

	drive_t pending_drive_q[$];

	// Receiver control: hold_req and quiet_run written by the stimulus process only at clock edges
	logic hold_req  = 1'b0;
	logic hold_seen = 1'b0;
	logic quiet_run = 1'b0;
	int   hold_left = 0;

	int stuck_cycles    = 0;
	int mismatches      = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int sweeps_expected = 0;
	int reg_writes      = 0;

	pan_tracking_mode_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.command   (command),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.speed     (speed),
		.mode      (mode),
		.sweeping  (sweeping),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Advance the predicted state by one item; return 1 with the drive on a tick
	function automatic bit advance_pan(input logic act, input logic [CMD_W-1:0] cmd,
			input logic signed [POS_W-1:0] pos, output drive_t d);
		logic signed [SPEED_W-1:0] track_mag;
		logic signed [SPEED_W-1:0] sweep_mag;
		track_mag = {1'b0, r_track};
		sweep_mag = {1'b0, r_sweep};
		d = '0;
		if (act == ACT_COMMAND) begin
			ever_cmd = 1'b1;
			ms_since_cmd = '0;
			if (cmd != CMD_LOST) begin
				lost_armed = 1'b0;
				lost_ms = '0;
			end
			mode_now = cmd;
			return 1'b0;
		end
		// Saturating timers, then the command timeout
		if (ms_since_cmd != TIMER_MAX)
			ms_since_cmd = ms_since_cmd + 1'b1;
		if (lost_armed && lost_ms != TIMER_MAX)
			lost_ms = lost_ms + 1'b1;
		if (ever_cmd && ms_since_cmd > r_timeout)
			mode_now = CMD_HOLD;
		case (mode_now)
			CMD_POS: begin
				if (pos < r_high)
					d.speed = track_mag;
			end
			CMD_NEG: begin
				if (pos > r_low)
					d.speed = -track_mag;
			end
			CMD_LOST: begin
				if (!lost_armed) begin
					lost_armed = 1'b1;
					lost_ms = '0;
				end else if (lost_ms > r_delay) begin
					// Turn at the limits; the low limit wins when both apply
					if (pos >= r_high)
						sweep_down = 1'b1;
					if (pos <= r_low)
						sweep_down = 1'b0;
					d.speed = sweep_down ? -sweep_mag : sweep_mag;
					d.sweeping = 1'b1;
				end
			end
			default: ;
		endcase
		d.mode = mode_now;
		return 1'b1;
	endfunction

	// Position near a limit most of the time, else anywhere or at an extreme
	function automatic logic [POS_W-1:0] pick_position();
		int r;
		int off;
		int v;
		r = $urandom_range(0, 9);
		off = $urandom_range(0, 6);
		if (r == 8)
			return 16'($urandom);
		if (r < 4)
			v = int'(r_low) + off - 3;
		else if (r < 8)
			v = int'(r_high) + off - 3;
		else
			v = $urandom_range(0, 1) ? 32767 : -32768;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[POS_W-1:0];
	endfunction

	function automatic logic [CMD_W-1:0] pick_command();
		int r;
		r = $urandom_range(0, 19);
		if (r < 7)
			return CMD_LOST;
		if (r < 11)
			return CMD_POS;
		if (r < 15)
			return CMD_NEG;
		if (r < 17)
			return CMD_HOLD;
		return 3'($urandom_range(4, 7));
	endfunction

	// Offer one item, hold it until accepted, then record its expected drive
	task automatic send_item(input logic act, input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] pos, input logic typed, input drive_t want);
		int gap;
		drive_t d;
		gap = 0;
		while (!quiet_run && gap < 12 && $urandom_range(0, 99) < 30)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		command  <= cmd;
		position <= pos;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (advance_pan(act, cmd, $signed(pos), d)) begin
			if (typed)
				d = want;
			if (d.sweeping)
				sweeps_expected++;
			pending_drive_q.push_back(d);
		end
	endtask

	// Stop offering and wait until every expected drive has come back
	task automatic settle_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_drive_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		settle_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_TRACK_SPEED: r_track   = value[SPEED_CFG_W-1:0];
			REG_SWEEP_SPEED: r_sweep   = value[SPEED_CFG_W-1:0];
			REG_LOW_LIMIT:   r_low     = value;
			REG_HIGH_LIMIT:  r_high    = value;
			REG_TIMEOUT:     r_timeout = value;
			REG_DELAY:       r_delay   = value;
			default: ;
		endcase
	endtask

	// Load the register set for one phase: fixed corner sets for phases 0 to 2, random after
	task automatic setup_phase(input int p);
		int tr, sw, lo, hi, to, dl;
		case (p)
			0: begin
				tr = 1023; sw = 0; lo = -32768; hi = 32767; to = 65535; dl = 1;
			end
			1: begin
				tr = 0; sw = 1023; lo = 32767; hi = -32768; to = 1; dl = 65535;
			end
			2: begin
				tr = TRACK_SPEED_RST; sw = SWEEP_SPEED_RST; lo = LOW_LIMIT_RST;
				hi = HIGH_LIMIT_RST; to = TIMEOUT_RST; dl = DELAY_RST;
			end
			default: begin
				tr = $urandom_range(0, 1023);
				sw = $urandom_range(0, 1023);
				lo = int'($urandom_range(0, 4000)) - 2000;
				hi = lo + int'($urandom_range(0, 3000)) - 100;
				to = $urandom_range(8, 60);
				dl = $urandom_range(1, 20);
			end
		endcase
		write_register(REG_TRACK_SPEED, tr[DATA_W-1:0]);
		write_register(REG_SWEEP_SPEED, sw[DATA_W-1:0]);
		write_register(REG_LOW_LIMIT,   lo[DATA_W-1:0]);
		write_register(REG_HIGH_LIMIT,  hi[DATA_W-1:0]);
		write_register(REG_TIMEOUT,     to[DATA_W-1:0]);
		write_register(REG_DELAY,       dl[DATA_W-1:0]);
	endtask

	// Receiver: random stalls, one long hold-off on request, none in the quiet phase
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet_run || ($urandom_range(0, 99) >= 30);
		end
	end

	// Compare each result transaction with the oldest expected drive
	always @(posedge clk) begin
		drive_t want;
		if (out_valid && out_ready) begin
			if (pending_drive_q.size() == 0) begin
				$display("%0t: unexpected result speed %0d mode %0d sweeping %0b",
					$time, speed, mode, sweeping);
				mismatches++;
			end else begin
				want = pending_drive_q.pop_front();
				results_checked++;
				if (speed !== $signed(want.speed)) begin
					$display("%0t: speed expected %0d actual %0d",
						$time, $signed(want.speed), speed);
					mismatches++;
				end
				if (mode !== want.mode) begin
					$display("%0t: mode expected %0d actual %0d", $time, want.mode, mode);
					mismatches++;
				end
				if (sweeping !== want.sweeping) begin
					$display("%0t: sweeping expected %0b actual %0b",
						$time, want.sweeping, sweeping);
					mismatches++;
				end
			end
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		int n;
		int run;
		int k;
		bit paused;
		bit stall_sent;
		in_valid  = 1'b0;
		action    = ACT_COMMAND;
		command   = CMD_HOLD;
		position  = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_TRACK_SPEED;
		cfg_data  = '0;
		arst_n    = 1'b0;
		r_track   = TRACK_SPEED_RST;
		r_sweep   = SWEEP_SPEED_RST;
		r_low     = LOW_LIMIT_RST;
		r_high    = HIGH_LIMIT_RST;
		r_timeout = TIMEOUT_RST;
		r_delay   = DELAY_RST;
		mode_now     = CMD_HOLD;
		ever_cmd     = 1'b0;
		ms_since_cmd = '0;
		lost_armed   = 1'b0;
		lost_ms      = '0;
		sweep_down   = 1'b0;
		stall_sent   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset state, limit edges, timeout, sweep, swapped limits
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (DIRECTED[i].kind == ROW_CFG)
				write_register(DIRECTED[i].sel, DIRECTED[i].data);
			else
				send_item(DIRECTED[i].act, DIRECTED[i].sel, DIRECTED[i].data,
					DIRECTED[i].typed, DIRECTED[i].want);
		end

		// Random: one command followed by a run of ticks, per burst
		for (int p = 0; p < NUM_PHASES; p++) begin
			setup_phase(p);
			if (p == QUIET_PHASE)
				quiet_run <= 1'b1;
			n = 0;
			paused = 1'b0;
			while (n < PHASE_ITEMS) begin
				send_item(ACT_COMMAND, pick_command(), 16'($urandom), 1'b0, '0);
				run = $urandom_range(0, 24);
				for (k = 0; k < run; k++)
					send_item(ACT_TICK, 3'($urandom), pick_position(), 1'b0, '0);
				n += 1 + run;
				// Ask the receiver for its long hold-off while items keep coming
				if (p == STALL_PHASE && !stall_sent && n >= 40) begin
					hold_req <= ~hold_req;
					stall_sent = 1'b1;
				end
				// Let the pipeline drain once mid-phase
				if (!paused && n >= PHASE_ITEMS / 2) begin
					settle_results();
					paused = 1'b1;
				end
			end
			if (p == QUIET_PHASE)
				quiet_run <= 1'b0;
		end

		settle_results();
		$display("Sent %0d items over %0d register settings (%0d writes); checked %0d results",
			items_sent, NUM_PHASES + 1, reg_writes, results_checked);
		$display("Results in sweep: %0d, including a long receiver hold-off and drain pauses",
			sweeps_expected);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
